// ===== src/pgra_pkg.sv =====
// ----------------------------------------------------------------------------
// pgra_pkg
// Shared widths and types for the prime gap running average block.
// ----------------------------------------------------------------------------
package pgra_pkg;

    // width of the candidate, the gap, the count and the gap total
    localparam int VALUE_WIDTH = 32;
    // fraction bits of the running average
    localparam int FRAC_BITS   = 16;
    // width of the running average and of the divider's dividend
    localparam int AVG_WIDTH   = VALUE_WIDTH + FRAC_BITS;
    // width of the divider step counter
    localparam int STEP_WIDTH  = $clog2(AVG_WIDTH + 1);

    // last prime, prime count and gap total after reset
    localparam logic [VALUE_WIDTH-1:0] RESET_LAST  = VALUE_WIDTH'(2);
    localparam logic [VALUE_WIDTH-1:0] RESET_COUNT = VALUE_WIDTH'(1);
    localparam logic [VALUE_WIDTH-1:0] RESET_TOTAL = VALUE_WIDTH'(2);
    // first trial divisor
    localparam logic [VALUE_WIDTH-1:0] FIRST_DIVISOR = VALUE_WIDTH'(2);

    // command to the shared divider
    typedef struct packed {
        logic                   start;
        logic                   wide;      // full width pass for the average
        logic [VALUE_WIDTH-1:0] value;     // dividend before the fraction shift
        logic [VALUE_WIDTH-1:0] divisor;
    } div_cmd_t;

    // response from the shared divider
    typedef struct packed {
        logic                   done;
        logic [AVG_WIDTH-1:0]   quotient;
        logic [VALUE_WIDTH-1:0] remainder;
    } div_rsp_t;

endpackage

// ===== src/pgra_if.sv =====
// ----------------------------------------------------------------------------
// pgra channel interfaces
// Valid/ready channels for candidates in and statistics out.
// ----------------------------------------------------------------------------
interface pgra_in_if;

    logic                             valid;
    logic                             ready;
    logic [pgra_pkg::VALUE_WIDTH-1:0] candidate;

    modport source (output valid, output candidate, input ready);
    modport sink   (input valid, input candidate, output ready);

endinterface

interface pgra_out_if;

    logic                             valid;
    logic                             ready;
    logic                             is_prime;
    logic [pgra_pkg::VALUE_WIDTH-1:0] prime_gap;
    logic [pgra_pkg::VALUE_WIDTH-1:0] primes_seen;
    logic [pgra_pkg::AVG_WIDTH-1:0]   average_q16;

    modport source (output valid, output is_prime, output prime_gap,
                    output primes_seen, output average_q16, input ready);
    modport sink   (input valid, input is_prime, input prime_gap,
                    input primes_seen, input average_q16, output ready);

endinterface

// ===== src/pgra_divider.sv =====
// ----------------------------------------------------------------------------
// pgra_divider
// Restoring radix-2 divider, one quotient bit per cycle, shared by the
// trial division and the running average.
// ----------------------------------------------------------------------------
module pgra_divider
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  pgra_pkg::div_cmd_t   cmd,
    output pgra_pkg::div_rsp_t   rsp
);

    logic [pgra_pkg::STEP_WIDTH-1:0]  step_reg;
    logic                             done_reg;
    logic [pgra_pkg::VALUE_WIDTH-1:0] rem_reg;
    logic [pgra_pkg::AVG_WIDTH-1:0]   quo_reg;
    logic [pgra_pkg::VALUE_WIDTH-1:0] divisor_reg;

    logic [pgra_pkg::VALUE_WIDTH:0]   partial;
    logic [pgra_pkg::VALUE_WIDTH:0]   diff;
    logic                             fits;

    // one compare and subtract per step
    assign partial = {rem_reg, quo_reg[pgra_pkg::AVG_WIDTH-1]};
    assign diff    = partial - {1'b0, divisor_reg};
    assign fits    = (partial >= {1'b0, divisor_reg});

    // step counter and done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (step_reg == pgra_pkg::STEP_WIDTH'(1));
            if (cmd.start)
            begin
                step_reg <= cmd.wide ? pgra_pkg::STEP_WIDTH'(pgra_pkg::AVG_WIDTH)
                                     : pgra_pkg::STEP_WIDTH'(pgra_pkg::VALUE_WIDTH);
            end
            else if (step_reg != '0)
            begin
                step_reg <= step_reg - pgra_pkg::STEP_WIDTH'(1);
            end
        end
    end

    // datapath: dividend enters left aligned, quotient fills from the right
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            rem_reg     <= '0;
            quo_reg     <= pgra_pkg::AVG_WIDTH'(cmd.value) << pgra_pkg::FRAC_BITS;
            divisor_reg <= cmd.divisor;
        end
        else if (step_reg != '0)
        begin
            rem_reg <= fits ? diff[pgra_pkg::VALUE_WIDTH-1:0]
                            : partial[pgra_pkg::VALUE_WIDTH-1:0];
            quo_reg <= {quo_reg[pgra_pkg::AVG_WIDTH-2:0], fits};
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

// ===== src/prime_gap_running_average.sv =====
// ----------------------------------------------------------------------------
// prime_gap_running_average
// Trial division primality test with running prime gap statistics.
// ----------------------------------------------------------------------------
//  channel      dir  beat contents
//  candidates   in   candidate
//  stats        out  is_prime, prime_gap, primes_seen, average_q16
//
// Each trial divisor is one pass on the shared divider (issue, 32 steps,
// check); a candidate c runs up to floor(sqrt(c)) trials, then comes the
// statistics update and the 48-step average division.
// Reset: last prime 2, count 1, gap total 2; no result pending.
// A new candidate is taken while a result still waits on stats; a finished
// average waits in its own state until the output register is free.
// ----------------------------------------------------------------------------
module prime_gap_running_average
(
    input  logic       clk,
    input  logic       rst_n,
    pgra_in_if.sink    candidates,
    pgra_out_if.source stats
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TRIAL,
        ST_TRIAL_WAIT,
        ST_UPDATE,
        ST_AVG,
        ST_AVG_WAIT,
        ST_HOLD
    } state_t;

    localparam logic [pgra_pkg::VALUE_WIDTH-1:0] ALL_ONES = '1;

    state_t                           state_reg, state_next;
    logic [pgra_pkg::VALUE_WIDTH-1:0] cand_reg, cand_next;
    logic [pgra_pkg::VALUE_WIDTH-1:0] div_reg, div_next;
    logic                             prime_reg, prime_next;
    logic [pgra_pkg::VALUE_WIDTH-1:0] gap_reg, gap_next;
    logic [pgra_pkg::VALUE_WIDTH-1:0] last_reg, last_next;
    logic [pgra_pkg::VALUE_WIDTH-1:0] count_reg, count_next;
    logic [pgra_pkg::VALUE_WIDTH-1:0] total_reg, total_next;
    logic                             out_valid_reg, out_valid_next;
    logic                             out_prime_reg, out_prime_next;
    logic [pgra_pkg::VALUE_WIDTH-1:0] out_gap_reg, out_gap_next;
    logic [pgra_pkg::VALUE_WIDTH-1:0] out_count_reg, out_count_next;
    logic [pgra_pkg::AVG_WIDTH-1:0]   out_avg_reg, out_avg_next;

    pgra_pkg::div_cmd_t               div_cmd;
    pgra_pkg::div_rsp_t               div_rsp;

    logic [pgra_pkg::VALUE_WIDTH:0]   total_sum;
    logic [pgra_pkg::VALUE_WIDTH-1:0] new_gap;
    logic                             out_free;

    // shared divider
    pgra_divider u_divider
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (div_cmd),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        div_cmd.start   = (state_reg == ST_TRIAL) || (state_reg == ST_AVG);
        div_cmd.wide    = (state_reg == ST_AVG);
        div_cmd.value   = (state_reg == ST_AVG) ? total_reg : cand_reg;
        div_cmd.divisor = (state_reg == ST_AVG) ? count_reg : div_reg;
    end

    // statistics arithmetic
    assign new_gap   = cand_reg - last_reg;
    assign total_sum = {1'b0, total_reg} + {1'b0, new_gap};
    assign out_free  = !out_valid_reg || stats.ready;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        cand_next      = cand_reg;
        div_next       = div_reg;
        prime_next     = prime_reg;
        gap_next       = gap_reg;
        last_next      = last_reg;
        count_next     = count_reg;
        total_next     = total_reg;
        out_valid_next = out_valid_reg && !stats.ready;
        out_prime_next = out_prime_reg;
        out_gap_next   = out_gap_reg;
        out_count_next = out_count_reg;
        out_avg_next   = out_avg_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (candidates.valid)
                begin
                    cand_next = candidates.candidate;
                    div_next  = pgra_pkg::FIRST_DIVISOR;
                    if (candidates.candidate < pgra_pkg::FIRST_DIVISOR)
                    begin
                        prime_next = 1'b0;
                        state_next = ST_UPDATE;
                    end
                    else
                    begin
                        state_next = ST_TRIAL;
                    end
                end
            end
            ST_TRIAL:
            begin
                state_next = ST_TRIAL_WAIT;
            end
            ST_TRIAL_WAIT:
            begin
                if (div_rsp.done)
                begin
                    // divisor past the root: no factor found
                    if (div_reg > div_rsp.quotient[pgra_pkg::VALUE_WIDTH-1:0])
                    begin
                        prime_next = 1'b1;
                        state_next = ST_UPDATE;
                    end
                    else if (div_rsp.remainder == '0)
                    begin
                        prime_next = 1'b0;
                        state_next = ST_UPDATE;
                    end
                    else
                    begin
                        div_next   = div_reg + pgra_pkg::VALUE_WIDTH'(1);
                        state_next = ST_TRIAL;
                    end
                end
            end
            ST_UPDATE:
            begin
                gap_next = '0;
                if (prime_reg && (cand_reg > last_reg))
                begin
                    gap_next   = new_gap;
                    last_next  = cand_reg;
                    if (count_reg != ALL_ONES)
                    begin
                        count_next = count_reg + pgra_pkg::VALUE_WIDTH'(1);
                    end
                    total_next = total_sum[pgra_pkg::VALUE_WIDTH]
                                 ? ALL_ONES : total_sum[pgra_pkg::VALUE_WIDTH-1:0];
                end
                state_next = ST_AVG;
            end
            ST_AVG:
            begin
                state_next = ST_AVG_WAIT;
            end
            ST_AVG_WAIT, ST_HOLD:
            begin
                if ((state_reg == ST_HOLD) || div_rsp.done)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_prime_next = prime_reg;
                        out_gap_next   = gap_reg;
                        out_count_next = count_reg;
                        out_avg_next   = div_rsp.quotient;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_HOLD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            last_reg      <= pgra_pkg::RESET_LAST;
            count_reg     <= pgra_pkg::RESET_COUNT;
            total_reg     <= pgra_pkg::RESET_TOTAL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            last_reg      <= last_next;
            count_reg     <= count_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cand_reg      <= cand_next;
        div_reg       <= div_next;
        prime_reg     <= prime_next;
        gap_reg       <= gap_next;
        out_prime_reg <= out_prime_next;
        out_gap_reg   <= out_gap_next;
        out_count_reg <= out_count_next;
        out_avg_reg   <= out_avg_next;
    end

    assign candidates.ready  = (state_reg == ST_IDLE);
    assign stats.valid       = out_valid_reg;
    assign stats.is_prime    = out_prime_reg;
    assign stats.prime_gap   = out_gap_reg;
    assign stats.primes_seen = out_count_reg;
    assign stats.average_q16 = out_avg_reg;

endmodule
